// File: rtl/igdt_pkg.sv
`default_nettype none
package igdt_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int CHAR_W         = 8;
  localparam int GROUP_SIZE     = 3;
  localparam int GRP_W          = 2;

  localparam logic [CHAR_W-1:0] SEP_CHAR   = 8'h2C;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // controls from the sequencer to the double-dabble shifter
  typedef struct packed {
    logic load;
    logic bit_step;
    logic dig_step;
  } dab_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/igdt_dabble.sv
`default_nettype none
module igdt_dabble import igdt_pkg::*; #(
  parameter int EFF_BITS = VALUE_BITS_DEF,
  parameter int NDIG     = 10
) (
  input  wire logic                clk,
  input  wire dab_ctrl_t           ctrl,
  input  wire logic [VALUE_W-1:0]  value,
  output logic [3:0]               top_digit
);

  localparam int BCD_W = NDIG * 4;

  logic [EFF_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [BCD_W-1:0]    bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] >= 4'd5) begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[d*4 +: 4] = bcd_r[d*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    priority if (ctrl.load) begin
      bin_nxt = value[EFF_BITS-1:0];
      bcd_nxt = '0;
    end else if (ctrl.bit_step) begin
      bin_nxt = {bin_r[EFF_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[EFF_BITS-1]};
    end else if (ctrl.dig_step) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end else begin
      // hold
      bin_nxt = bin_r;
      bcd_nxt = bcd_r;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule
`default_nettype wire

// File: rtl/integer_to_grouped_decimal_text.sv
`default_nettype none
// channel  | ports                                  | carries
// ---------+----------------------------------------+--------------------------------
// input    | in_valid, in_ready, in_value           | one unsigned integer per item
// result   | out_valid, out_ready, out_text_char,   | one ascii character per item,
//          | out_last_char                          | last_char marks end of the text
//
// one integer at a time: it is loaded, run through bit-serial double-dabble
// over its VALUE_BITS (32) bits, then its leading zero digits are dropped (up to
// 9) and the text is started, then its characters (up to 13) go out one per
// cycle while out_ready is held high and the output register drains.
// in_ready is high only when the sequencer is idle; the last character may
// still wait in the output register while the next integer is taken.
// reset (synchronous, rst_n low) returns the sequencer to idle and empties
// the output register. a stall on out_ready freezes character emission.
module integer_to_grouped_decimal_text import igdt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [CHAR_W-1:0]       out_text_char,
  output logic                    out_last_char
);

  // only the low VALUE_BITS bits of the input count
  localparam int EFF_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  // decimal digits of 2^EFF_BITS - 1: floor(n * log10 2) + 1
  localparam int NDIG     = ((EFF_BITS * 1233) >> 12) + 1;
  localparam int BCW      = $clog2(EFF_BITS + 1);
  localparam int DCW      = $clog2(NDIG + 1);
  localparam logic [GRP_W-1:0] INIT_MOD  = GRP_W'(NDIG % GROUP_SIZE);
  localparam logic [GRP_W-1:0] MOD_WRAP  = GRP_W'(GROUP_SIZE - 1);

  state_t            state_r, state_nxt;
  logic [BCW-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [DCW-1:0]    dig_cnt_r, dig_cnt_nxt;   // digits left, current one included
  logic [GRP_W-1:0]  mod_r, mod_nxt;           // dig_cnt_r modulo group size
  logic              first_r, first_nxt;       // next digit opens the text
  logic              comma_done_r, comma_done_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  dab_ctrl_t         dab_ctrl;
  logic [3:0]        top_digit;
  logic              slot_free;
  logic [GRP_W-1:0]  mod_dec;

  // shift register that turns the binary value into bcd digits
  igdt_dabble #(
    .EFF_BITS (EFF_BITS),
    .NDIG     (NDIG)
  ) u_dabble (
    .clk       (clk),
    .ctrl      (dab_ctrl),
    .value     (in_value),
    .top_digit (top_digit)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign mod_dec   = (mod_r == '0) ? MOD_WRAP : (mod_r - GRP_W'(1));

  always_comb begin
    state_nxt      = state_r;
    bit_cnt_nxt    = bit_cnt_r;
    dig_cnt_nxt    = dig_cnt_r;
    mod_nxt        = mod_r;
    first_nxt      = first_r;
    comma_done_nxt = comma_done_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    dab_ctrl       = '0;
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dab_ctrl.load = 1'b1;
          bit_cnt_nxt   = BCW'(EFF_BITS);
          state_nxt     = ST_CONV;
        end
      end

      ST_CONV: begin
        // one input bit enters the bcd digits per cycle
        dab_ctrl.bit_step = 1'b1;
        bit_cnt_nxt       = bit_cnt_r - BCW'(1);
        if (bit_cnt_r == BCW'(1)) begin
          dig_cnt_nxt = DCW'(NDIG);
          mod_nxt     = INIT_MOD;
          state_nxt   = ST_SKIP;
        end
      end

      ST_SKIP: begin
        // drop leading zeros, but always keep the units digit
        if (top_digit == 4'd0 && dig_cnt_r != DCW'(1)) begin
          dab_ctrl.dig_step = 1'b1;
          dig_cnt_nxt       = dig_cnt_r - DCW'(1);
          mod_nxt           = mod_dec;
        end else begin
          first_nxt      = 1'b1;
          comma_done_nxt = 1'b0;
          state_nxt      = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (!first_r && mod_r == '0 && !comma_done_r) begin
            // separator ahead of a full group of three
            out_char_nxt   = SEP_CHAR;
            out_last_nxt   = 1'b0;
            comma_done_nxt = 1'b1;
          end else begin
            out_char_nxt      = DIGIT_ZERO + {4'd0, top_digit};
            out_last_nxt      = (dig_cnt_r == DCW'(1));
            dab_ctrl.dig_step = 1'b1;
            dig_cnt_nxt       = dig_cnt_r - DCW'(1);
            mod_nxt           = mod_dec;
            first_nxt         = 1'b0;
            comma_done_nxt    = 1'b0;
            if (dig_cnt_r == DCW'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // counters and payload: only read once set up by the sequencer
  always_ff @(posedge clk) begin
    bit_cnt_r    <= bit_cnt_nxt;
    dig_cnt_r    <= dig_cnt_nxt;
    mod_r        <= mod_nxt;
    first_r      <= first_nxt;
    comma_done_r <= comma_done_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

endmodule
`default_nettype wire

// File: rtl/igdt_check.sv
`default_nettype none
module igdt_check import igdt_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] out_text_char,
  input wire logic              out_last_char
);

  // stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char)
      && $stable(out_last_char))
    else $error("stalled character changed");

  // only digits and separators appear
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == SEP_CHAR)
      || (out_text_char >= DIGIT_ZERO && out_text_char <= DIGIT_ZERO + 8'd9))
    else $error("character outside digit and separator set");

  // the text never ends on a separator
  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |-> out_text_char != SEP_CHAR)
    else $error("text ends on separator");

  // one integer at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second integer taken during conversion");

endmodule

bind integer_to_grouped_decimal_text igdt_check u_igdt_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_text_char (out_text_char),
  .out_last_char (out_last_char)
);
`default_nettype wire

// File: dv/grouped_text_checker.sv
`timescale 1ns / 1ps
// watches both channels, renders each accepted integer as grouped decimal text
// and compares every character that leaves the block against it
module grouped_text_checker import igdt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [CHAR_W-1:0]  out_text_char,
  input  wire logic               out_last_char,
  input  wire logic               at_end,
  output int                      fail_count,
  output int                      chars_waiting,
  output int                      chars_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t expected_text[$];
  int         mismatches    = 0;
  bit         leftover_told = 1'b0;

  initial chars_waiting = 0;
  initial chars_checked = 0;

  // characters still owed count against the run only once stimulus is over
  assign fail_count = mismatches + (at_end ? chars_waiting : 0);

  // digits least significant first, then emitted from the top with a comma
  // ahead of every full group of three that is not the leading one
  function automatic void queue_grouped_text(input logic [VALUE_W-1:0] value);
    logic [63:0]        mask;
    logic [63:0]        rest;
    logic [3:0]         digits[20];
    int                 ndig;
    text_char_t         entry;
    mask = ~64'd0 >> (64 - VALUE_BITS);
    rest = 64'(value) & mask;
    ndig = 0;
    do begin
      digits[ndig] = 4'(rest % 10);
      ndig++;
      rest = rest / 10;
    end while (rest != 0);
    for (int i = ndig - 1; i >= 0; i--) begin
      if (i != ndig - 1 && (i + 1) % GROUP_SIZE == 0) begin
        entry.ch   = SEP_CHAR;
        entry.last = 1'b0;
        expected_text = {expected_text, entry};
      end
      entry.ch   = DIGIT_ZERO + CHAR_W'(digits[i]);
      entry.last = (i == 0);
      expected_text = {expected_text, entry};
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        queue_grouped_text(in_value);
      end
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t unexpected char 8'h%h last=%0b with nothing owed",
                     $realtime, out_text_char, out_last_char);
          end
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== out_text_char || want.last !== out_last_char) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t char mismatch: expected 8'h%h last=%0b, got 8'h%h last=%0b",
                       $realtime, want.ch, want.last, out_text_char, out_last_char);
            end
          end
        end
      end
      chars_waiting <= expected_text.size();
    end
    if (at_end && !leftover_told && expected_text.size() != 0) begin
      leftover_told = 1'b1;
      $display("%0d expected chars never came out", expected_text.size());
    end
  end

endmodule

// File: dv/tb_integer_to_grouped_decimal_text.sv
`timescale 1ns / 1ps
module tb_integer_to_grouped_decimal_text;
  import igdt_pkg::*;

  // traffic phases; the receiver picks its stall rate from the current one
  typedef enum int {
    PH_DIRECTED,
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE,
    PH_PRESSURE
  } phase_t;

  localparam int HOLD_CYCLES = 400;   // long receiver hold-off to back the block up
  localparam int QUIET_LIMIT = 3000;  // cycles without any handshake before giving up
  localparam int TAIL_CYCLES = 60;    // a bit more than one full conversion

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [VALUE_W-1:0] in_value  = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_text_char;
  logic               out_last_char;

  logic   at_end = 1'b0;
  phase_t phase  = PH_DIRECTED;
  int     fail_count;
  int     chars_waiting;
  int     chars_checked;
  int     items_sent = 0;
  int     quiet_cycles = 0;

  integer_to_grouped_decimal_text u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char)
  );

  grouped_text_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .at_end        (at_end),
    .fail_count    (fail_count),
    .chars_waiting (chars_waiting),
    .chars_checked (chars_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall rate per phase, in percent
  function automatic int stall_pct(input phase_t ph);
    case (ph)
      PH_RECV_STALL: return 62;
      PH_BOTH_IDLE:  return 38;
      default:       return 0;
    endcase
  endfunction

  // mostly values of a chosen digit count, so every text length and comma
  // position shows up; some exact decade edges and some raw 32-bit noise
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned       kind;
    int unsigned       ndig;
    longint unsigned   lo;
    longint unsigned   hi;
    kind = $urandom_range(9);
    if (kind < 2) return $urandom;
    ndig = $urandom_range(10, 1);
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    if (kind == 2) return lo[31:0];
    if (kind == 3) return hi[31:0];
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  // offer one integer; entered and left just after the clock rises
  task automatic offer_value(input logic [VALUE_W-1:0] value, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic run_phase(input phase_t ph, input int count, input int idle_pct);
    phase <= ph;
    repeat (count) offer_value(pick_value(), idle_pct);
  endtask

  // stop offering until every character owed has come out
  task automatic wait_text_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [VALUE_W-1:0] directed_values[$];
    // zero, every digit count at its low and high edge, all-ones, bit patterns
    directed_values = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999, 32'd1000000,
      32'd9999999, 32'd10000000, 32'd99999999, 32'd100000000, 32'd999999999,
      32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) offer_value(directed_values[i], 0);

    run_phase(PH_FREE, 40, 0);
    run_phase(PH_SEND_IDLE, 50, 62);
    run_phase(PH_RECV_STALL, 50, 0);
    run_phase(PH_BOTH_IDLE, 60, 38);

    // empty pipe first, then hold the receiver off while items keep coming
    wait_text_drained();
    run_phase(PH_PRESSURE, 30, 0);
    run_phase(PH_FREE, 26, 0);

    wait_text_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    at_end <= 1'b1;
    @(posedge clk);

    $display("covered %0d integers (zero, all decade edges, full 32-bit range) -> %0d chars",
             items_sent, chars_checked);
    $display("traffic: free flow, idle sender, stalling receiver, both, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: random stalls by phase, one long hold-off in the pressure phase
  initial begin
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (phase == PH_PRESSURE && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct(phase));
    end
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
